>>> design/stg_pkg.sv
package stg_pkg;

    localparam int FREQ_W      = 16;
    localparam int SAMPLE_W    = 12;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 16;
    localparam int TABLE_DEPTH = 32;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

    localparam logic [SAMPLE_W-1:0] SINE_TABLE [TABLE_DEPTH] = '{
        12'd2048, 12'd2447, 12'd2831, 12'd3185, 12'd3495, 12'd3750, 12'd3939, 12'd4056,
        12'd4095, 12'd4056, 12'd3939, 12'd3750, 12'd3495, 12'd3185, 12'd2831, 12'd2447,
        12'd2048, 12'd1648, 12'd1264, 12'd910,  12'd600,  12'd345,  12'd156,  12'd39,
        12'd0,    12'd39,   12'd156,  12'd345,  12'd600,  12'd910,  12'd1264, 12'd1648
    };

    typedef struct packed {
        logic              silent;
        logic [FREQ_W-1:0] freq;
    } cmd_t;

    typedef struct packed {
        logic              start;
        logic [FREQ_W-1:0] divisor;
    } div_req_t;

    typedef enum logic {
        BK_RUN,
        BK_DIV
    } back_state_t;

endpackage

>>> design/stg_front.sv
module stg_front
    import stg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_IN_W-1:0] s_tdata,   // [15:0] freq_hz
    output logic                  cmd_valid,
    output cmd_t                  cmd,
    input  logic                  cmd_ready
);

    localparam int QDEPTH = 2;
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    cmd_t             q0_reg, q0_next;
    cmd_t             q1_reg, q1_next;
    cmd_t             new_cmd;
    logic             push, pop;

    assign new_cmd.freq   = s_tdata[FREQ_W-1:0];
    assign new_cmd.silent = (s_tdata[FREQ_W-1:0] == '0);

    assign s_tready  = (count_reg != CNT_W'(QDEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q0_reg;
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        count_next = count_reg;
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        case ({push, pop})
            2'b10: begin
                if (count_reg == '0) begin
                    q0_next = new_cmd;
                end else begin
                    q1_next = new_cmd;
                end
                count_next = count_reg + CNT_W'(1);
            end
            2'b01: begin
                q0_next    = q1_reg;
                count_next = count_reg - CNT_W'(1);
            end
            2'b11: begin
                if (count_reg == CNT_W'(1)) begin
                    q0_next = new_cmd;
                end else begin
                    q0_next = q1_reg;
                    q1_next = new_cmd;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

>>> design/stg_divider.sv
module stg_divider
    import stg_pkg::*;
#(
    parameter int CLOCK_HZ = 50000000,
    parameter int CLK_W    = $clog2(CLOCK_HZ + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  div_req_t         req,
    output logic             done,
    output logic [CLK_W-1:0] quotient
);

    localparam int               STEP_W   = $clog2(CLK_W + 1);
    localparam logic [CLK_W-1:0] DIVIDEND = CLK_W'(CLOCK_HZ);

    logic [STEP_W-1:0] steps_reg, steps_next;
    logic              done_reg, done_next;
    logic [FREQ_W-1:0] rem_reg, rem_next;
    logic [CLK_W-1:0]  quo_reg, quo_next;
    logic [FREQ_W-1:0] div_reg, div_next;
    logic [FREQ_W:0]   rem_sh;
    logic [FREQ_W+1:0] diff;

    assign rem_sh = {rem_reg, quo_reg[CLK_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, div_reg};

    always_comb begin
        steps_next = steps_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        if (req.start) begin
            steps_next = STEP_W'(CLK_W);
            rem_next   = '0;
            quo_next   = DIVIDEND;
            div_next   = req.divisor;
        end else if (steps_reg != '0) begin
            if (!diff[FREQ_W+1]) begin
                rem_next = diff[FREQ_W-1:0];
            end else begin
                rem_next = rem_sh[FREQ_W-1:0];
            end
            quo_next   = {quo_reg[CLK_W-2:0], !diff[FREQ_W+1]};
            steps_next = steps_reg - STEP_W'(1);
            done_next  = (steps_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            steps_reg <= steps_next;
            done_reg  <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> design/stg_back.sv
module stg_back
    import stg_pkg::*;
#(
    parameter int CLOCK_HZ = 50000000,
    parameter int CLK_W    = $clog2(CLOCK_HZ + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cmd_valid,
    input  cmd_t                   cmd,
    output logic                   cmd_ready,
    output div_req_t               div_req,
    input  logic                   div_done,
    input  logic [CLK_W-1:0]       div_quotient,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata    // [11:0] sample_out
);

    localparam int IW = CLK_W - TABLE_AW;

    back_state_t         state_reg, state_next;
    logic [TABLE_AW-1:0] phase_reg, phase_next;
    logic [IW-1:0]       tick_reg, tick_next;
    logic [IW-1:0]       interval_reg, interval_next;
    logic [SAMPLE_W-1:0] held_reg, held_next;
    logic                out_valid_reg, out_valid_next;
    logic [IW:0]         tick_sum;
    logic                latch;
    logic                fire;

    assign tick_sum  = {1'b0, tick_reg} + (IW + 1)'(1);
    assign latch     = (tick_sum >= {1'b0, interval_reg});
    assign cmd_ready = (state_reg == BK_RUN) && (!out_valid_reg || m_tready);
    assign fire      = cmd_valid && cmd_ready;

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        interval_next  = interval_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg && !m_tready;
        div_req.start  = 1'b0;
        div_req.divisor = cmd.freq;
        unique case (state_reg)
            BK_RUN: begin
                if (fire) begin
                    out_valid_next = 1'b1;
                    if (cmd.silent) begin
                        held_next = '0;
                    end else if (latch) begin
                        held_next     = SINE_TABLE[phase_reg];
                        phase_next    = phase_reg + TABLE_AW'(1);
                        tick_next     = '0;
                        div_req.start = 1'b1;
                        state_next    = BK_DIV;
                    end else begin
                        tick_next = tick_sum[IW-1:0];
                    end
                end
            end
            BK_DIV: begin
                if (div_done) begin
                    interval_next = div_quotient[CLK_W-1:TABLE_AW];
                    state_next    = BK_RUN;
                end
            end
            default: begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_RUN;
            phase_reg     <= '0;
            tick_reg      <= '0;
            interval_reg  <= IW'(1);
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            interval_reg  <= interval_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_OUT_W - SAMPLE_W){1'b0}}, held_reg};

`ifndef ASSERT_OFF
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == BK_DIV))
        else $error("divider result with no pending recompute");

    a_start_enters_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |=> (state_reg == BK_DIV) && (tick_reg == '0))
        else $error("latch did not enter recompute");

    a_tick_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (tick_reg == '0) || (tick_reg < interval_reg))
        else $error("tick counter passed interval");
`endif

endmodule

>>> design/sine_tone_generator_core.sv
// An item goes through the front queue, then the sample register.
// Throughput: 1 item per cycle with m_tready high and no table step.
// A table step recomputes the interval in a bit-serial divider:
// the back end then stalls until the divider is done.
// A 2-entry queue absorbs input during that stall.
// Reset: synchronous, active low; sample 0, phase 0, counter 0, interval 1.
module sine_tone_generator_core
    import stg_pkg::*;
#(
    parameter int CLOCK_HZ = 50000000
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // [15:0] freq_hz
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata    // [11:0] sample_out
);

    localparam int CLK_W = $clog2(CLOCK_HZ + 1);

    logic             cmd_valid;
    cmd_t             cmd;
    logic             cmd_ready;
    div_req_t         div_req;
    logic             div_done;
    logic [CLK_W-1:0] div_quotient;

    stg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    stg_divider #(
        .CLOCK_HZ (CLOCK_HZ),
        .CLK_W    (CLK_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quotient)
    );

    stg_back #(
        .CLOCK_HZ (CLOCK_HZ),
        .CLK_W    (CLK_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_ready    (cmd_ready),
        .div_req      (div_req),
        .div_done     (div_done),
        .div_quotient (div_quotient),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule
